[rtl/shadow_pixel_relight_core_macros.svh]
// assertion macros shared by the checker of the relight core
// depends on nothing; the using scope must provide clk and rst_n
`ifndef SHADOW_PIXEL_RELIGHT_CORE_MACROS_SVH
`define SHADOW_PIXEL_RELIGHT_CORE_MACROS_SVH

// same-cycle implication, muted while reset is asserted
`define SPR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("relight core check failed");

// next-cycle implication, muted while reset is asserted
`define SPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("relight core check failed");

`endif

[rtl/spr_pkg.sv]
// shared widths, stage indexes, register codes and control struct of the relight core
// depends on nothing
package spr_pkg;

    localparam int CH_W     = 8;                    // one color channel or matte
    localparam int NUM_CH   = 3;
    localparam int GAIN_W   = 24;                   // unsigned q8.16
    localparam int OFFS_W   = 25;                   // signed q.8
    localparam int FRAC_W   = 16;                   // target held in q.16
    localparam int T_W      = 35;                   // signed target
    localparam int NUM_W    = 50;                   // signed numerator
    localparam int DEN_W    = 44;                   // signed denominator
    localparam int AN_W     = NUM_W - 1;            // numerator magnitude
    localparam int AD_W     = DEN_W - 1;            // denominator magnitude
    localparam int Q_W      = 8;                    // quotient bits
    localparam int DIV_W    = AD_W + 1 + Q_W;       // divider remainder width
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W = (NUM_CH + 1) * CH_W;
    localparam int M_DATA_W = NUM_CH * CH_W;

    localparam logic [CH_W-1:0]   CH_MAX     = '1;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

    // lane stage indexes
    localparam int ST_TGT  = 0;                     // target
    localparam int ST_PROD = 1;                     // numerator and denominator
    localparam int ST_SIGN = 2;                     // signs, magnitudes, special cases
    localparam int ST_SUM  = 3;                     // rounding offset
    localparam int ST_SAT  = 4;                     // saturation check
    localparam int ST_DIV0 = 5;                     // first quotient bit

    localparam int LANE_STAGES = ST_DIV0 + Q_W;
    localparam int PIPE_STAGES = LANE_STAGES + 1;   // plus output register

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_CH0 = 3'd0,
        REG_GAIN_CH1 = 3'd1,
        REG_GAIN_CH2 = 3'd2,
        REG_OFFS_CH0 = 3'd3,
        REG_OFFS_CH1 = 3'd4,
        REG_OFFS_CH2 = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [LANE_STAGES-1:0] lane_ld;            // load enable per lane stage
        logic                   out_ld;             // load enable of output register
        logic                   relit;              // word in last lane stage is relit
    } pipe_ctl_t;

endpackage

[rtl/spr_lane.sv]
// one channel lane: target, products, signs, rounding, saturation and a bit-per-stage divider
// depends on spr_pkg
module spr_lane (
    input  logic                              clk,
    input  spr_pkg::pipe_ctl_t                ctl,
    input  logic        [spr_pkg::CH_W-1:0]   lum,
    input  logic        [spr_pkg::CH_W-1:0]   matte,
    input  logic        [spr_pkg::GAIN_W-1:0] gain,
    input  logic signed [spr_pkg::OFFS_W-1:0] offs,
    output logic        [spr_pkg::CH_W-1:0]   res,
    output logic        [spr_pkg::CH_W-1:0]   lum_out
);
    import spr_pkg::*;

    // target stage
    logic [GAIN_W+CH_W-1:0] gl;
    logic [T_W-1:0]         t_next;
    logic signed [T_W-1:0]  a_t_reg;
    logic [CH_W-1:0]        a_lum_reg;
    logic [CH_W-1:0]        a_m_reg;

    assign gl     = gain * lum;
    assign t_next = {{(T_W-GAIN_W-CH_W){1'b0}}, gl}
                  + {{(T_W-OFFS_W-CH_W){offs[OFFS_W-1]}}, offs, {CH_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (ctl.lane_ld[ST_TGT])
        begin
            a_t_reg   <= t_next;
            a_lum_reg <= lum;
            a_m_reg   <= matte;
        end
    end

    // product stage
    logic [2*CH_W-1:0]            lum255;
    logic [2*CH_W-1:0]            ml;
    logic [CH_W-1:0]              inv_m;
    logic signed [T_W+2*CH_W:0]   num_full;
    logic signed [DEN_W-1:0]      den_full;
    logic [NUM_W-1:0]             b_num_reg;
    logic [DEN_W-1:0]             b_den_reg;
    logic                         b_lz_reg;
    logic [CH_W-1:0]              b_lum_reg;

    assign lum255   = {a_lum_reg, {CH_W{1'b0}}} - {{CH_W{1'b0}}, a_lum_reg};
    assign ml       = a_m_reg * a_lum_reg;
    assign inv_m    = CH_MAX - a_m_reg;
    assign num_full = a_t_reg * $signed({1'b0, lum255});
    assign den_full = a_t_reg * $signed({1'b0, inv_m})
                    + $signed({{(DEN_W-2*CH_W-FRAC_W){1'b0}}, ml, {FRAC_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (ctl.lane_ld[ST_PROD])
        begin
            b_num_reg <= num_full[NUM_W-1:0];
            b_den_reg <= den_full;
            b_lz_reg  <= (a_lum_reg == '0);
            b_lum_reg <= a_lum_reg;
        end
    end

    // sign stage
    logic             num_neg;
    logic             den_neg;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic             frc_next;
    logic [CH_W-1:0]  fval_next;
    logic [AN_W-1:0]  c_an_reg;
    logic [AD_W-1:0]  c_ad_reg;
    logic             c_frc_reg;
    logic [CH_W-1:0]  c_fval_reg;
    logic [CH_W-1:0]  c_lum_reg;

    assign num_neg = b_num_reg[NUM_W-1];
    assign den_neg = b_den_reg[DEN_W-1];
    assign num_mag = num_neg ? (~b_num_reg + 1'b1) : b_num_reg;
    assign den_mag = den_neg ? (~b_den_reg + 1'b1) : b_den_reg;

    always_comb
    begin
        frc_next  = 1'b1;
        fval_next = '0;
        if (b_lz_reg)
        begin
            fval_next = '0;
        end
        else if (b_den_reg == '0)
        begin
            // zero denominator: saturate on a positive numerator
            fval_next = (!num_neg && (b_num_reg != '0)) ? CH_MAX : '0;
        end
        else if ((b_num_reg == '0) || (num_neg != den_neg))
        begin
            fval_next = '0;
        end
        else
        begin
            frc_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.lane_ld[ST_SIGN])
        begin
            c_an_reg   <= num_mag[AN_W-1:0];
            c_ad_reg   <= den_mag[AD_W-1:0];
            c_frc_reg  <= frc_next;
            c_fval_reg <= fval_next;
            c_lum_reg  <= b_lum_reg;
        end
    end

    // rounding stage: n = 2|num| + |den|, d = 2|den|
    logic [DIV_W-1:0] d_n_reg;
    logic [AD_W:0]    d_d_reg;
    logic             d_frc_reg;
    logic [CH_W-1:0]  d_fval_reg;
    logic [CH_W-1:0]  d_lum_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.lane_ld[ST_SUM])
        begin
            d_n_reg    <= {{(DIV_W-AN_W-1){1'b0}}, c_an_reg, 1'b0}
                        + {{(DIV_W-AD_W){1'b0}}, c_ad_reg};
            d_d_reg    <= {c_ad_reg, 1'b0};
            d_frc_reg  <= c_frc_reg;
            d_fval_reg <= c_fval_reg;
            d_lum_reg  <= c_lum_reg;
        end
    end

    // saturation stage and divider chain, entry 0 fed by the saturation stage
    logic [DIV_W-1:0] dv_r_reg    [Q_W+1];
    logic [AD_W:0]    dv_d_reg    [Q_W+1];
    logic [Q_W-1:0]   dv_q_reg    [Q_W+1];
    logic             dv_frc_reg  [Q_W+1];
    logic [CH_W-1:0]  dv_fval_reg [Q_W+1];
    logic [CH_W-1:0]  dv_lum_reg  [Q_W+1];
    logic             sat;

    // quotient at or above 256 clamps
    assign sat = (d_n_reg >= {d_d_reg, {Q_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (ctl.lane_ld[ST_SAT])
        begin
            dv_r_reg[0]    <= d_n_reg;
            dv_d_reg[0]    <= d_d_reg;
            dv_q_reg[0]    <= '0;
            dv_frc_reg[0]  <= d_frc_reg || sat;
            dv_fval_reg[0] <= d_frc_reg ? d_fval_reg : CH_MAX;
            dv_lum_reg[0]  <= d_lum_reg;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        localparam int SH = Q_W - 1 - k;
        logic [DIV_W-1:0] dsh;
        logic             take;

        assign dsh  = {{Q_W{1'b0}}, dv_d_reg[k]} << SH;
        assign take = (dv_r_reg[k] >= dsh);

        always_ff @(posedge clk)
        begin
            if (ctl.lane_ld[ST_DIV0+k])
            begin
                dv_r_reg[k+1]     <= take ? (dv_r_reg[k] - dsh) : dv_r_reg[k];
                dv_d_reg[k+1]     <= dv_d_reg[k];
                dv_q_reg[k+1]     <= dv_q_reg[k] | ({{(Q_W-1){1'b0}}, take} << SH);
                dv_frc_reg[k+1]   <= dv_frc_reg[k];
                dv_fval_reg[k+1]  <= dv_fval_reg[k];
                dv_lum_reg[k+1]   <= dv_lum_reg[k];
            end
        end
    end

    assign res     = dv_frc_reg[Q_W] ? dv_fval_reg[Q_W] : dv_q_reg[Q_W];
    assign lum_out = dv_lum_reg[Q_W];

endmodule

[rtl/spr_ctrl.sv]
// valid and ready chain of the pipeline, carries the relit flag beside each word
// depends on spr_pkg
module spr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               relit_in,
    input  logic               m_tready,
    output logic               s_tready,
    output logic               m_tvalid,
    output logic               m_relit,
    output spr_pkg::pipe_ctl_t ctl
);
    import spr_pkg::*;

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [PIPE_STAGES-1:0] rel_reg;
    logic [PIPE_STAGES-1:0] rel_next;
    logic [PIPE_STAGES-1:0] rdy;
    logic [PIPE_STAGES-1:0] in_v;
    logic [PIPE_STAGES-1:0] in_r;
    logic [PIPE_STAGES-1:0] ld;

    for (genvar k = 0; k < PIPE_STAGES; k++)
    begin : g_stage
        // a stage may take a word when the output is taken or any stage from it to the output is free
        assign rdy[k] = m_tready | ~(&vld_reg[PIPE_STAGES-1:k]);
        if (k == 0)
        begin : g_head
            assign in_v[k] = s_tvalid;
            assign in_r[k] = relit_in;
        end
        else
        begin : g_body
            assign in_v[k] = vld_reg[k-1];
            assign in_r[k] = rel_reg[k-1];
        end
        assign ld[k]       = rdy[k] & in_v[k];
        assign vld_next[k] = rdy[k] ? in_v[k] : vld_reg[k];
        assign rel_next[k] = ld[k] ? in_r[k] : rel_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg <= rel_next;
    end

    assign s_tready    = rdy[0];
    assign m_tvalid    = vld_reg[PIPE_STAGES-1];
    assign m_relit     = rel_reg[PIPE_STAGES-1];
    assign ctl.lane_ld = ld[LANE_STAGES-1:0];
    assign ctl.out_ld  = ld[PIPE_STAGES-1];
    assign ctl.relit   = rel_reg[LANE_STAGES-1];

endmodule

[rtl/spr_merge.sv]
// output register: joins the lane results, or passes the pixel when not relit
// depends on spr_pkg
module spr_merge (
    input  logic                                          clk,
    input  spr_pkg::pipe_ctl_t                            ctl,
    input  logic [spr_pkg::NUM_CH-1:0][spr_pkg::CH_W-1:0] res,
    input  logic [spr_pkg::NUM_CH-1:0][spr_pkg::CH_W-1:0] lum,
    output logic [spr_pkg::M_DATA_W-1:0]                  data
);
    import spr_pkg::*;

    logic [NUM_CH-1:0][CH_W-1:0] data_reg;
    logic [NUM_CH-1:0][CH_W-1:0] data_next;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            data_next[ch] = ctl.relit ? res[ch] : lum[ch];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_ld)
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

[rtl/shadow_pixel_relight_core.sv]
// an accepted input word passes the lane stages and then the output register to its output word
// throughput: one pixel per cycle while the output is taken; each of the three lanes retires
// one quotient bit per stage; a stalled output still lets new words in until every stage is full
// reset: rst_n asynchronous active low clears all valid bits and restores the
// gain registers to 1.0 and the offset registers to 0; data registers are not reset
module shadow_pixel_relight_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [spr_pkg::OFFS_W-1:0]           cfg_data,
    // input pixel stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [spr_pkg::S_DATA_W-1:0]         s_tdata,   // pix_ch0, pix_ch1, pix_ch2, matte_val
    // output pixel stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [spr_pkg::M_DATA_W-1:0]         m_tdata,   // out_ch0, out_ch1, out_ch2
    output logic                                 m_tuser    // relit
);
    import spr_pkg::*;

    // per-channel correction registers
    logic [GAIN_W-1:0]        gain_reg [NUM_CH];
    logic signed [OFFS_W-1:0] offs_reg [NUM_CH];

    // writes are always taken; an index past the list is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                gain_reg[ch] <= GAIN_RESET;
                offs_reg[ch] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_CH0: gain_reg[0] <= cfg_data[GAIN_W-1:0];
                REG_GAIN_CH1: gain_reg[1] <= cfg_data[GAIN_W-1:0];
                REG_GAIN_CH2: gain_reg[2] <= cfg_data[GAIN_W-1:0];
                REG_OFFS_CH0: offs_reg[0] <= cfg_data;
                REG_OFFS_CH1: offs_reg[1] <= cfg_data;
                REG_OFFS_CH2: offs_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // unpack the input word
    logic [CH_W-1:0] matte;
    logic            relit_in;

    assign matte    = s_tdata[NUM_CH*CH_W +: CH_W];
    assign relit_in = (matte != '0);

    // handshake and stage enables shared by all lanes
    pipe_ctl_t ctl;

    spr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .relit_in (relit_in),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_relit  (m_tuser),
        .ctl      (ctl)
    );

    // one lane per channel, all in lockstep
    logic [NUM_CH-1:0][CH_W-1:0] lane_res;
    logic [NUM_CH-1:0][CH_W-1:0] lane_lum;

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        spr_lane u_lane (
            .clk     (clk),
            .ctl     (ctl),
            .lum     (s_tdata[ch*CH_W +: CH_W]),
            .matte   (matte),
            .gain    (gain_reg[ch]),
            .offs    (offs_reg[ch]),
            .res     (lane_res[ch]),
            .lum_out (lane_lum[ch])
        );
    end

    // a zero matte passes the original channels through
    spr_merge u_merge (
        .clk  (clk),
        .ctl  (ctl),
        .res  (lane_res),
        .lum  (lane_lum),
        .data (m_tdata)
    );

endmodule

[rtl/spr_checker.sv]
// port-level checks of the relight core and the bind that attaches them
// depends on spr_pkg and shadow_pixel_relight_core_macros.svh
`include "shadow_pixel_relight_core_macros.svh"

module spr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [spr_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import spr_pkg::*;

    // a held output word keeps its contents
    `SPR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // a draining output frees every stage
    `SPR_ASSERT_IMPL(a_ready_follows, m_tready, s_tready)
    // an empty output register means the pipeline has room
    `SPR_ASSERT_IMPL(a_empty_ready, !m_tvalid, s_tready)
    // a fresh output word was accepted at the input and came through the pipeline without stalling
    `SPR_ASSERT_IMPL(a_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, PIPE_STAGES))

endmodule

bind shadow_pixel_relight_core spr_checker u_spr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench of the shadow pixel relight core: predicts every output word
// in a small scoreboard class and drives the stream and configuration ports with tasks
// depends on spr_pkg and shadow_pixel_relight_core
module tb_top;

    import spr_pkg::*;

    // run limits
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = PIPE_STAGES + 6;   // latency plus margin
    localparam int          LONG_HOLD    = 80;                // receiver hold-off, cycles
    localparam int          MAX_REPORTS  = 10;
    localparam int          RAND_PHASES  = 6;
    localparam int          PHASE_WORDS  = 64;

    // register indexes beyond the list, writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    // register extremes
    localparam logic [GAIN_W-1:0] GAIN_MAX      = '1;
    localparam logic [OFFS_W-1:0] OFFS_LOW      = OFFS_W'(-16646400);
    localparam logic [OFFS_W-1:0] OFFS_HIGH     = OFFS_W'(65280);
    localparam logic [OFFS_W-1:0] OFFS_TOP_POS  = {1'b0, {(OFFS_W-1){1'b1}}};
    localparam logic [OFFS_W-1:0] OFFS_SIGN_BIT = {1'b1, {(OFFS_W-1){1'b0}}};
    localparam longint            Q16_ONE       = 64'd65536;

    // input word, last field in the lowest bits
    typedef struct packed {
        logic [CH_W-1:0] matte;
        logic [CH_W-1:0] ch2;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch0;
    } pixel_t;

    // expected output word
    typedef struct {
        logic [CH_W-1:0] ch[NUM_CH];
        logic            relit;
    } relit_pixel_t;

    // register shadow, exact predictor and expected-word store
    class relight_scoreboard;
        logic [GAIN_W-1:0] gain[NUM_CH];
        logic [OFFS_W-1:0] offs[NUM_CH];
        relit_pixel_t      expected_pixels[$];
        int                failures;

        function new();
            for (int k = 0; k < NUM_CH; k++)
            begin
                gain[k] = GAIN_RESET;
                offs[k] = '0;
            end
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFFS_W-1:0] data);
            case (cfg_reg_t'(idx))
                REG_GAIN_CH0, REG_GAIN_CH1, REG_GAIN_CH2:
                    gain[idx] = data[GAIN_W-1:0];
                REG_OFFS_CH0, REG_OFFS_CH1, REG_OFFS_CH2:
                    offs[idx - REG_OFFS_CH0] = data;
                default:
                    ;
            endcase
        endfunction

        // round(255*t*l / ((255-m)*t + m*l)) with t in signed q.16, exact
        function logic [CH_W-1:0] relit_value(logic [CH_W-1:0] lum, logic [CH_W-1:0] matte,
                                              logic [GAIN_W-1:0] g, logic [OFFS_W-1:0] o);
            longint l, m, gv, ov, t, num, den, an, ad, q;
            l  = lum;
            m  = matte;
            gv = g;
            ov = $signed(o);
            if (l == 0)
                return '0;
            t   = gv * l + ov * 256;
            num = longint'(CH_MAX) * t * l;
            den = (longint'(CH_MAX) - m) * t + m * l * Q16_ONE;
            if (den == 0)
                return (num > 0) ? CH_MAX : '0;
            if (num == 0 || ((num < 0) != (den < 0)))
                return '0;
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            q  = (2 * an + ad) / (2 * ad);
            return (q > longint'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
        endfunction

        function void note_pixel(pixel_t px);
            relit_pixel_t exp_px;
            logic [CH_W-1:0] lum[NUM_CH];
            lum[0] = px.ch0;
            lum[1] = px.ch1;
            lum[2] = px.ch2;
            for (int k = 0; k < NUM_CH; k++)
                exp_px.ch[k] = (px.matte == 0) ? lum[k]
                                               : relit_value(lum[k], px.matte, gain[k], offs[k]);
            exp_px.relit = (px.matte != 0);
            expected_pixels.push_back(exp_px);
        endfunction

        function void report(string what, int unsigned exp_val, int unsigned got_val);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("[%0t] mismatch on %s: expected %0d, got %0d",
                         $realtime, what, exp_val, got_val);
        endfunction

        function void check_pixel(logic [M_DATA_W-1:0] data, logic relit);
            relit_pixel_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("[%0t] output word 0x%06h with nothing expected", $realtime, data);
                return;
            end
            exp_px = expected_pixels.pop_front();
            for (int k = 0; k < NUM_CH; k++)
                if (data[k*CH_W +: CH_W] !== exp_px.ch[k])
                    report($sformatf("out_ch%0d", k), exp_px.ch[k], data[k*CH_W +: CH_W]);
            if (relit !== exp_px.relit)
                report("relit", exp_px.relit, relit);
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // block inputs, known from time zero
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [OFFS_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tready  = 1'b0;

    logic                 cfg_ready;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;

    shadow_pixel_relight_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // pix_ch0, pix_ch1, pix_ch2, matte_val
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // out_ch0, out_ch1, out_ch2
        .m_tuser   (m_tuser)       // relit
    );

    relight_scoreboard sb = new();

    // monitors: every handshake is observed at the edge where it happens
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (rst_n && s_tvalid && s_tready)
            sb.note_pixel(pixel_t'(s_tdata));
        if (rst_n && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tuser);
    end

    // watchdog
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall pattern, redrawn when its random run length expires, plus a long
    // hold-off whenever the stimulus bumps hold_token
    int unsigned hold_token = 0;
    int unsigned hold_seen  = 0;
    int          hold_left  = 0;
    int          pat_left   = 0;
    int          pat_mode   = 0;

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_mode <= $urandom_range(0, 3);
                pat_left <= $urandom_range(8, 64);
            end
            else
                pat_left <= pat_left - 1;
            case (pat_mode)
                0:       m_tready <= 1'b1;                         // no stalls
                1:       m_tready <= 1'($urandom_range(0, 1));     // coin flip
                2:       m_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
                default: m_tready <= (pat_left % 3 != 0);          // periodic gap
            endcase
        end
    end

    // sender burst state
    int burst_left = 0;
    bit steady     = 1'b0;   // no gaps between bursts

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFFS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // all six channel registers, then the channel goes quiet
    task automatic set_channel_regs(logic [OFFS_W-1:0] g0, logic [OFFS_W-1:0] g1,
                                    logic [OFFS_W-1:0] g2, logic [OFFS_W-1:0] o0,
                                    logic [OFFS_W-1:0] o1, logic [OFFS_W-1:0] o2);
        write_reg(REG_GAIN_CH0, g0);
        write_reg(REG_GAIN_CH1, g1);
        write_reg(REG_GAIN_CH2, g2);
        write_reg(REG_OFFS_CH0, o0);
        write_reg(REG_OFFS_CH1, o1);
        write_reg(REG_OFFS_CH2, o2);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one input word, with a random gap at the start of each burst unless steady is set
    task automatic send_pixel(logic [CH_W-1:0] c0, logic [CH_W-1:0] c1,
                              logic [CH_W-1:0] c2, logic [CH_W-1:0] matte);
        pixel_t px;
        int     gap;
        px = '{matte: matte, ch2: c2, ch1: c1, ch0: c0};
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop sending and let every expected word come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [OFFS_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {1'b0, GAIN_MAX};
            2, 3:    return OFFS_W'($urandom_range(32'h4000, 32'h40000));   // 0.25 .. 4.0
            default: return OFFS_W'($urandom);   // top bit is dropped by the block
        endcase
    endfunction

    function automatic logic [OFFS_W-1:0] pick_offset();
        int v;
        v = $urandom_range(0, 130560) - 65280;   // within +-255.0
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return OFFS_LOW;
            2:       return OFFS_HIGH;
            3, 4:    return OFFS_W'(v);
            default: return OFFS_W'($urandom);   // any bit pattern
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_chan();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CH_MAX;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_matte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CH_MAX;
            2:       return CH_W'(1);
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: gain 1.0 offset 0 gives the identity, zero matte passes through
        send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel(8'hAA,  8'h55,  8'h0F,  8'd0);
        send_pixel(8'd255, 8'd1,   8'd128, 8'd255);
        send_pixel(8'd200, 8'd17,  8'd0,   8'd1);
        wait_idle();

        // register extremes; writes to spare indexes must not land anywhere
        write_reg(IDX_SPARE_LO, '1);
        write_reg(IDX_SPARE_HI, OFFS_SIGN_BIT);
        set_channel_regs({1'b1, GAIN_MAX}, '0, OFFS_W'(Q16_ONE),
                         OFFS_HIGH, OFFS_LOW, OFFS_TOP_POS);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd1,   8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd1);
        send_pixel(8'd128, 8'd64,  8'd32,  8'd128);
        send_pixel(8'd0,   8'd0,   8'd255, 8'd200);
        wait_idle();

        // zero gain: offset -2.0 hits a zero denominator, -1.0 a negative quotient,
        // 0 a zero numerator; gain data with only its unused top bit set reads as zero
        set_channel_regs('0, '0, OFFS_SIGN_BIT,
                         OFFS_W'(-512), OFFS_W'(-256), '0);
        send_pixel(8'd1,   8'd100, 8'd50,  8'd170);
        send_pixel(8'd2,   8'd255, 8'd1,   8'd170);
        send_pixel(8'd1,   8'd1,   8'd1,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd255, 8'd85);
        wait_idle();

        // half gain, half offset: rounding on exact halves
        set_channel_regs(OFFS_W'(32'h8000), OFFS_W'(32'h8000), OFFS_W'(32'h8000),
                         OFFS_W'(32'h80), OFFS_W'(32'h80), OFFS_W'(32'h80));
        send_pixel(8'd3,   8'd7,   8'd200, 8'd100);
        send_pixel(8'd255, 8'd128, 8'd1,   8'd254);
        send_pixel(8'd10,  8'd20,  8'd30,  8'd40);
        wait_idle();

        // random phases, each with fresh registers
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_channel_regs(pick_gain(), pick_gain(), pick_gain(),
                             pick_offset(), pick_offset(), pick_offset());
            steady = (ph == 1);
            // output held off while input keeps coming, so the pipe fills and backs up
            if (ph == 1)
                hold_token <= hold_token + 1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // sender pause until everything in flight is out
                if (ph == 3 && n == PHASE_WORDS / 2)
                    wait_idle();
                send_pixel(pick_chan(), pick_chan(), pick_chan(), pick_matte());
            end
            wait_idle();
        end

        if (sb.failures == 0 && sb.expected_pixels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
